@@ rtl/sodc_pkg.sv @@
package sodc_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_RECAL  = 2'd1,
    OP_RESUME = 2'd2,
    OP_STOP   = 2'd3
  } opcode_t;

  // Result word kinds
  typedef enum logic [1:0] {
    KIND_DAC      = 2'd0,
    KIND_PROGRESS = 2'd1,
    KIND_REPORT   = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WIN_LOW    = 2'd0,
    REG_WIN_HIGH   = 2'd1,
    REG_FIRST_STEP = 2'd2,
    REG_RECAL_STEP = 2'd3
  } reg_idx_t;

  localparam int SAMPLE_W = 12;
  localparam int DAC_W    = 16;

  localparam logic [SAMPLE_W-1:0] WIN_LOW_RST    = 12'd1997;
  localparam logic [SAMPLE_W-1:0] WIN_HIGH_RST   = 12'd2097;
  localparam logic [SAMPLE_W-1:0] FIRST_STEP_RST = 12'd1023;
  localparam logic [SAMPLE_W-1:0] RECAL_STEP_RST = 12'd200;
  localparam logic [DAC_W-1:0]    DAC_RST        = 16'd2047;
  localparam logic [SAMPLE_W-1:0] STEP_RST       = 12'd1023;

endpackage

@@ rtl/sensor_offset_dac_calibrator.sv @@
// A result word is registered in the output stage before it reaches the out_ ports.
// Throughput: one input word per cycle while in_stall is low; the state update is a single add/compare stage.
// A two-entry output stage (result register plus skid register) lets input flow on
// while a result waits; in_stall rises only when both entries are full.
// Reset (rst_n low, synchronous): registers to defaults, DAC 2047, step 1023,
// calibration active in its first phase, reporting off, output stage empty.
module sensor_offset_dac_calibrator
  import sodc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [SAMPLE_W-1:0] in_sample,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_result_kind,
  output logic [DAC_W-1:0]    out_value,
  output logic                out_calibrating
);

  typedef enum logic [1:0] {
    PH_MOVE   = 2'd0,
    PH_CHECK  = 2'd1,
    PH_REPORT = 2'd2
  } phase_t;

  // configuration registers
  logic [SAMPLE_W-1:0] win_low_r, win_high_r, first_step_r, recal_step_r;

  // calibration state
  logic [DAC_W-1:0]    dac_r, dac_nxt;
  logic [SAMPLE_W-1:0] step_r, step_nxt;
  logic                dir_r, dir_nxt;
  phase_t              phase_r, phase_nxt;
  logic                active_r, active_nxt;
  logic                reached_r, reached_nxt;
  logic                from_cmd_r, from_cmd_nxt;
  logic                rep_on_r, rep_on_nxt;

  // output stage: head register and skid register
  logic                head_valid_r, skid_valid_r;
  logic [1:0]          head_kind_r, skid_kind_r;
  logic [DAC_W-1:0]    head_value_r, skid_value_r;
  logic                head_cal_r, skid_cal_r;

  // result of the current word
  logic                res_valid;
  kind_t               res_kind;
  logic [DAC_W-1:0]    res_value;
  logic                res_cal;

  logic                accept, pop;
  logic                at_low, at_high, in_win;
  logic [SAMPLE_W-1:0] step_fix;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign pop      = head_valid_r && !out_stall;

  assign out_valid       = head_valid_r;
  assign out_result_kind = head_kind_r;
  assign out_value       = head_value_r;
  assign out_calibrating = head_cal_r;

  // window compares
  assign at_low  = in_sample <= win_low_r;
  assign at_high = in_sample >= win_high_r;
  assign in_win  = (in_sample >= win_low_r) && (in_sample <= win_high_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r    <= WIN_LOW_RST;
      win_high_r   <= WIN_HIGH_RST;
      first_step_r <= FIRST_STEP_RST;
      recal_step_r <= RECAL_STEP_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WIN_LOW:    win_low_r    <= cfg_data;
        REG_WIN_HIGH:   win_high_r   <= cfg_data;
        REG_FIRST_STEP: first_step_r <= cfg_data;
        REG_RECAL_STEP: recal_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-word state update and result
  always_comb begin
    dac_nxt      = dac_r;
    step_nxt     = step_r;
    dir_nxt      = dir_r;
    phase_nxt    = phase_r;
    active_nxt   = active_r;
    reached_nxt  = reached_r;
    from_cmd_nxt = from_cmd_r;
    rep_on_nxt   = rep_on_r;
    res_valid    = 1'b0;
    res_kind     = KIND_DAC;
    res_value    = dac_r;
    res_cal      = 1'b1;
    step_fix     = step_r;

    case (opcode_t'(in_opcode))
      OP_RECAL: begin
        active_nxt   = 1'b1;
        phase_nxt    = PH_MOVE;
        from_cmd_nxt = 1'b1;
        reached_nxt  = 1'b0;
      end
      OP_RESUME: rep_on_nxt = 1'b1;
      OP_STOP:   rep_on_nxt = 1'b0;
      default: begin
        if (!active_r) begin
          res_valid = rep_on_r;
          res_kind  = KIND_REPORT;
          res_value = {{(DAC_W-SAMPLE_W){1'b0}}, in_sample};
          res_cal   = 1'b0;
        end else begin
          case (phase_r)
            // check window, adapt step
            PH_CHECK: begin
              if (in_win) begin
                reached_nxt = 1'b1;
              end else if (step_r == '0) begin
                step_fix = {{(SAMPLE_W-1){1'b0}}, 1'b1};
              end
              if ((at_low && dir_r) || (at_high && !dir_r)) begin
                step_nxt = step_fix >> 1;
              end else begin
                step_nxt = step_fix;
              end
              phase_nxt = PH_REPORT;
            end
            // progress report, maybe finish
            PH_REPORT: begin
              if (reached_r) begin
                active_nxt  = 1'b0;
                rep_on_nxt  = 1'b1;
                step_nxt    = from_cmd_r ? recal_step_r : first_step_r;
                reached_nxt = 1'b0;
              end
              phase_nxt = PH_MOVE;
              res_valid = 1'b1;
              res_kind  = KIND_PROGRESS;
              res_value = {{(DAC_W-SAMPLE_W){1'b0}}, in_sample};
            end
            // move the DAC (also any unused phase code)
            default: begin
              if (at_low) begin
                dac_nxt = dac_r - {{(DAC_W-SAMPLE_W){1'b0}}, step_r};
                dir_nxt = 1'b0;
              end else if (at_high) begin
                dac_nxt = dac_r + {{(DAC_W-SAMPLE_W){1'b0}}, step_r};
                dir_nxt = 1'b1;
              end
              reached_nxt = 1'b0;
              phase_nxt   = PH_CHECK;
              res_valid   = 1'b1;
              res_kind    = KIND_DAC;
              res_value   = dac_nxt;
            end
          endcase
        end
      end
    endcase
  end

  // calibration state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dac_r      <= DAC_RST;
      step_r     <= STEP_RST;
      dir_r      <= 1'b0;
      phase_r    <= PH_MOVE;
      active_r   <= 1'b1;
      reached_r  <= 1'b0;
      from_cmd_r <= 1'b0;
      rep_on_r   <= 1'b0;
    end else if (accept) begin
      dac_r      <= dac_nxt;
      step_r     <= step_nxt;
      dir_r      <= dir_nxt;
      phase_r    <= phase_nxt;
      active_r   <= active_nxt;
      reached_r  <= reached_nxt;
      from_cmd_r <= from_cmd_nxt;
      rep_on_r   <= rep_on_nxt;
    end
  end

  // output stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop || !head_valid_r) begin
        // head free this cycle: refill from skid, else from new result
        if (skid_valid_r) begin
          head_valid_r <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          head_valid_r <= accept && res_valid;
        end
      end else if (accept && res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (pop || !head_valid_r) begin
      if (skid_valid_r) begin
        head_kind_r  <= skid_kind_r;
        head_value_r <= skid_value_r;
        head_cal_r   <= skid_cal_r;
      end else if (accept && res_valid) begin
        head_kind_r  <= res_kind;
        head_value_r <= res_value;
        head_cal_r   <= res_cal;
      end
    end else if (accept && res_valid) begin
      skid_kind_r  <= res_kind;
      skid_value_r <= res_value;
      skid_cal_r   <= res_cal;
    end
  end

`ifndef ASSERT_OFF
  // skid entry is only ever filled behind a full head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid register full while head empty");

  // idle calibration always sits in its first phase
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> phase_r == PH_MOVE)
    else $error("calibration idle outside first phase");

  // reports carry calibrating low, other kinds carry it high
  a_kind_cal: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid_r |-> (head_cal_r == (head_kind_r != KIND_REPORT)))
    else $error("calibrating flag does not match result kind");

  // a drained head with nothing behind it and no new result goes empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !skid_valid_r && !(accept && res_valid) |=> !head_valid_r)
    else $error("result word repeated after hand-over");

  // a first-phase sample during calibration advances to the check phase
  a_dac_phase: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_opcode == OP_SAMPLE && active_r && phase_r == PH_MOVE
      |=> phase_r == PH_CHECK)
    else $error("first phase did not advance");
`endif

endmodule

@@ bench/sensor_offset_dac_calibrator_tb.sv @@
module sensor_offset_dac_calibrator_tb;
  import sodc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int WORDS_PER_SETTING = 190;
  localparam int NUM_SETTINGS = 6;

  // one result word as it leaves the block
  typedef struct packed {
    kind_t             kind;
    logic [DAC_W-1:0]  value;
    logic              calibrating;
  } result_t;

  // one row of the directed script; pinned rows carry a hand-written expectation
  typedef struct packed {
    opcode_t               op;
    logic [SAMPLE_W-1:0]   smp;
    bit                    pinned;
    bit                    some;
    result_t               word;
  } script_row_t;

  typedef enum logic [1:0] {
    PH_MOVE   = 2'd0,
    PH_CHECK  = 2'd1,
    PH_REPORT = 2'd2
  } cal_phase_t;

  localparam result_t NO_WORD = '{KIND_DAC, 16'd0, 1'b0};
  localparam int SCRIPT_LEN = 26;

  // after reset: window 1997..2097, DAC 2047, step 1023
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{OP_SAMPLE, 12'd0,    1'b1, 1'b1, '{KIND_DAC,      16'd1024, 1'b1}},
    '{OP_SAMPLE, 12'd0,    1'b1, 1'b0, NO_WORD},
    '{OP_SAMPLE, 12'd0,    1'b1, 1'b1, '{KIND_PROGRESS, 16'd0,    1'b1}},
    '{OP_SAMPLE, 12'd0,    1'b1, 1'b1, '{KIND_DAC,      16'd1,    1'b1}},
    '{OP_SAMPLE, 12'd0,    1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 12'd4095, 1'b1, 1'b1, '{KIND_PROGRESS, 16'd4095, 1'b1}},
    '{OP_SAMPLE, 12'd0,    1'b0, 1'b0, NO_WORD},   // DAC wraps below zero
    '{OP_SAMPLE, 12'd4095, 1'b0, 1'b0, NO_WORD},   // overshoot halves step
    '{OP_SAMPLE, 12'd2000, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 12'd4095, 1'b0, 1'b0, NO_WORD},   // DAC steps up by the halved step
    '{OP_SAMPLE, 12'd0,    1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 12'd2047, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 12'd2047, 1'b0, 1'b0, NO_WORD},   // inside: DAC left alone
    '{OP_STOP,   12'd0,    1'b1, 1'b0, NO_WORD},   // stop while calibrating
    '{OP_SAMPLE, 12'd1997, 1'b0, 1'b0, NO_WORD},   // low edge is inside
    '{OP_SAMPLE, 12'd12,   1'b0, 1'b0, NO_WORD},   // end of calibration
    '{OP_SAMPLE, 12'd0,    1'b1, 1'b1, '{KIND_REPORT,   16'd0,    1'b0}},
    '{OP_STOP,   12'd4095, 1'b1, 1'b0, NO_WORD},
    '{OP_SAMPLE, 12'd5,    1'b1, 1'b0, NO_WORD},
    '{OP_RESUME, 12'd0,    1'b0, 1'b0, NO_WORD},
    '{OP_RECAL,  12'd4095, 1'b1, 1'b0, NO_WORD},
    '{OP_SAMPLE, 12'd2097, 1'b0, 1'b0, NO_WORD},   // first phase after recalibrate
    '{OP_RECAL,  12'd0,    1'b1, 1'b0, NO_WORD},   // recalibrate mid-round
    '{OP_SAMPLE, 12'd2097, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 12'd2097, 1'b0, 1'b0, NO_WORD},   // high edge is inside
    '{OP_SAMPLE, 12'd4000, 1'b0, 1'b0, NO_WORD}
  };

  // block inputs, all known from time zero
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [SAMPLE_W-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic [1:0]          in_opcode = '0;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_stall = 1'b0;

  logic                in_stall;
  logic                out_valid;
  logic [1:0]          out_result_kind;
  logic [DAC_W-1:0]    out_value;
  logic                out_calibrating;

  // predictor copy of registers and state
  logic [SAMPLE_W-1:0] win_lo, win_hi, step_first, step_recal;
  logic [DAC_W-1:0]    cal_dac;
  logic [DAC_W-1:0]    cal_step;
  logic                last_raised;
  cal_phase_t          cal_phase;
  logic                cal_busy;
  logic                in_window;
  logic                recal_armed;
  logic                report_en;

  result_t             pending_words [$];
  int unsigned         mismatches = 0;
  int unsigned         words_in = 0;
  int unsigned         kinds_seen [3] = '{0, 0, 0};
  int unsigned         quiet_cycles = 0;
  int unsigned         send_idle_pct = 12;
  int unsigned         stall_pct = 61;

  // expectation override for pinned script rows
  bit                  pin_on = 1'b0;
  bit                  pin_some = 1'b0;
  result_t             pin_word = NO_WORD;

  sensor_offset_dac_calibrator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_value       (out_value),
    .out_calibrating (out_calibrating)
  );

  always #4 clk = ~clk;

  // advance the calibration state by one input word; returns 1 if a word comes out
  function automatic bit calib_step(input opcode_t op, input logic [SAMPLE_W-1:0] smp,
                                    output result_t word);
    bit some;
    some = 1'b0;
    word = NO_WORD;
    case (op)
      OP_RECAL: begin
        cal_busy = 1'b1;
        cal_phase = PH_MOVE;
        recal_armed = 1'b1;
        in_window = 1'b0;
      end
      OP_RESUME: report_en = 1'b1;
      OP_STOP:   report_en = 1'b0;
      default: begin
        if (!cal_busy) begin
          if (report_en) begin
            some = 1'b1;
            word = '{KIND_REPORT, {4'd0, smp}, 1'b0};
          end
        end else if (cal_phase == PH_CHECK) begin
          if (smp >= win_lo && smp <= win_hi) in_window = 1'b1;
          else if (cal_step == '0) cal_step = 16'd1;
          // overshoot past the far edge: halve
          if ((smp <= win_lo && last_raised) || (smp >= win_hi && !last_raised))
            cal_step = cal_step >> 1;
          cal_phase = PH_REPORT;
        end else if (cal_phase == PH_REPORT) begin
          if (in_window) begin
            cal_busy = 1'b0;
            report_en = 1'b1;
            cal_step = recal_armed ? {4'd0, step_recal} : {4'd0, step_first};
            in_window = 1'b0;
          end
          cal_phase = PH_MOVE;
          some = 1'b1;
          word = '{KIND_PROGRESS, {4'd0, smp}, 1'b1};
        end else begin
          if (smp <= win_lo) begin
            cal_dac = cal_dac - cal_step;
            last_raised = 1'b0;
          end else if (smp >= win_hi) begin
            cal_dac = cal_dac + cal_step;
            last_raised = 1'b1;
          end
          in_window = 1'b0;
          cal_phase = PH_CHECK;
          some = 1'b1;
          word = '{KIND_DAC, cal_dac, 1'b1};
        end
      end
    endcase
    return some;
  endfunction

  task automatic flag_mismatch(input string what, input logic [DAC_W-1:0] want,
                               input logic [DAC_W-1:0] got);
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // present one input word and hold it until taken
  task automatic send_word(input opcode_t op, input logic [SAMPLE_W-1:0] smp,
                           input bit pinned, input bit some, input result_t word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_sample <= smp;
    pin_on    = pinned;
    pin_some  = some;
    pin_word  = word;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  // drain, let the pipe settle, then write all four registers
  task automatic write_settings(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi,
                                input logic [SAMPLE_W-1:0] first, input logic [SAMPLE_W-1:0] recal);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIN_LOW;    cfg_data <= lo;    @(negedge clk);
    cfg_index <= REG_WIN_HIGH;   cfg_data <= hi;    @(negedge clk);
    cfg_index <= REG_FIRST_STEP; cfg_data <= first; @(negedge clk);
    cfg_index <= REG_RECAL_STEP; cfg_data <= recal; @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // predictor update and result check, on the rising edge
  always @(posedge clk) begin : result_monitor
    result_t want_word;
    bit      want_some;
    if (!rst_n) begin
      win_lo      = WIN_LOW_RST;
      win_hi      = WIN_HIGH_RST;
      step_first  = FIRST_STEP_RST;
      step_recal  = RECAL_STEP_RST;
      cal_dac     = DAC_RST;
      cal_step    = {4'd0, STEP_RST};
      last_raised = 1'b0;
      cal_phase   = PH_MOVE;
      cal_busy    = 1'b1;
      in_window   = 1'b0;
      recal_armed = 1'b0;
      report_en   = 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_WIN_LOW:    win_lo = cfg_data;
          REG_WIN_HIGH:   win_hi = cfg_data;
          REG_FIRST_STEP: step_first = cfg_data;
          default:        step_recal = cfg_data;
        endcase
      end
      if (in_valid && !in_stall) begin
        words_in++;
        want_some = calib_step(opcode_t'(in_opcode), in_sample, want_word);
        if (pin_on) begin
          want_some = pin_some;
          want_word = pin_word;
        end
        if (want_some) pending_words.push_back(want_word);
      end
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          flag_mismatch("result word with nothing pending, value", '0, out_value);
        end else begin
          want_word = pending_words.pop_front();
          kinds_seen[want_word.kind]++;
          if (out_result_kind !== want_word.kind)
            flag_mismatch("result_kind", 16'(want_word.kind), 16'(out_result_kind));
          if (out_value !== want_word.value)
            flag_mismatch("value", want_word.value, out_value);
          if (out_calibrating !== want_word.calibrating)
            flag_mismatch("calibrating", 16'(want_word.calibrating), 16'(out_calibrating));
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] timeout: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("sensor_offset_dac_calibrator: mismatch");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned         target;
    int unsigned         pick;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] smp;
    opcode_t             op;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed script on reset defaults
    for (int r = 0; r < SCRIPT_LEN; r++)
      send_word(SCRIPT[r].op, SCRIPT[r].smp, SCRIPT[r].pinned, SCRIPT[r].some, SCRIPT[r].word);

    // random words under several register settings
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: write_settings(WIN_LOW_RST, WIN_HIGH_RST, FIRST_STEP_RST, RECAL_STEP_RST);
        1: write_settings(12'd0, 12'd4095, 12'd4095, 12'd0);     // whole range is inside
        2: write_settings(12'd4095, 12'd0, 12'd0, 12'd4095);     // inverted window
        3: write_settings(12'd1000, 12'd1100, 12'd1, 12'd7);
        4: begin
          lo = 12'($urandom_range(3000));
          write_settings(lo, lo + 12'($urandom_range(1000)), 12'($urandom), 12'($urandom));
        end
        default: write_settings(12'd2000, 12'd2000, 12'd4095, 12'd4095); // one-point window
      endcase
      send_idle_pct = (s < 2) ? 12 : (s < 4) ? 61 : 0;
      stall_pct     = (s < 2) ? 61 : (s < 4) ? 12 : 0;
      target = words_in + WORDS_PER_SETTING;
      while (words_in < target) begin
        pick = $urandom_range(99);
        if (pick < 30) smp = 12'($urandom_range(win_hi, win_lo));
        else if (pick < 55) begin
          case ($urandom_range(3))
            0:       smp = win_lo;
            1:       smp = win_hi;
            2:       smp = win_lo - 12'd1;
            default: smp = win_hi + 12'd1;
          endcase
        end else if (pick < 70) smp = $urandom_range(1) ? 12'hFFF : 12'h000;
        else smp = 12'($urandom_range(4095));
        pick = $urandom_range(99);
        op = (pick < 86) ? OP_SAMPLE : (pick < 91) ? OP_RECAL : (pick < 96) ? OP_RESUME : OP_STOP;
        send_word(op, smp, 1'b0, 1'b0, NO_WORD);
      end
    end

    // drain and let any late word show up
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("covered: %0d input words over %0d register settings plus the reset defaults",
             words_in, NUM_SETTINGS);
    $display("checked: %0d DAC writes, %0d progress samples, %0d reports, %0d mismatches",
             kinds_seen[KIND_DAC], kinds_seen[KIND_PROGRESS], kinds_seen[KIND_REPORT],
             mismatches);
    if (mismatches == 0) begin
      $display("sensor_offset_dac_calibrator: match");
    end else begin
      $display("sensor_offset_dac_calibrator: mismatch");
    end
    $finish;
  end

endmodule
